// ===== rtl/mbw_pkg.sv =====
// shared types, constants and a helper function of the msb-first bit writer
`default_nettype none

package mbw_pkg;

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int NBITS_W  = 5;
	localparam int BYTE_W   = 8;
	localparam int VBITS_W  = 4;
	localparam int FIELD_W  = 39;
	localparam int ACC_W    = FIELD_W + BYTE_W - 1;
	localparam int CNT_W    = 6;

	localparam logic [VBITS_W-1:0] FULL_BYTE = 4'd8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_RAW      = 2'd0,
		ACT_SIGNED   = 2'd1,
		ACT_POS_CODE = 2'd2,
		ACT_FLUSH    = 2'd3
	} action_t;

	// minimal width of an unsigned value, zero takes one bit
	function automatic logic [CNT_W-1:0] width_of(input logic [VALUE_W-1:0] v);
		logic [CNT_W-1:0] w;
		w = CNT_W'(1);
		for (int i = 1; i < VALUE_W; i++) begin
			if (v[i]) begin
				w = CNT_W'(i + 1);
			end
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mbw_if.sv =====
// request channels of the msb-first bit writer: input items and output bytes
`default_nettype none

interface mbw_in_if import mbw_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic signed [VALUE_W-1:0]  field_value;
	logic [NBITS_W-1:0]         field_bits;

	modport source (output valid, action, field_value, field_bits, input ready);
	modport sink (input valid, action, field_value, field_bits, output ready);
endinterface

interface mbw_out_if import mbw_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [BYTE_W-1:0]    out_byte;
	logic [VBITS_W-1:0]   valid_bits;
	logic                 last;

	modport source (output valid, out_byte, valid_bits, last, input ready);
	modport sink (input valid, out_byte, valid_bits, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/msb_first_bit_writer_core.sv =====
// msb-first bit writer: packs raw, signed and length-coded fields into bytes
//
// An accepted request is decoded into one left-aligned bit field of up to 39
// bits in the input register; once the byte accumulator holds less than a byte
// and no flush is pending, it is merged behind the bits still waiting there, and
// from then on one byte leaves per cycle through the output register while the
// output is not stalled. A request that completes k bytes (at most five) holds
// the accumulator until those bytes have left, so the request rate is set by
// the single byte-wide output register.
`default_nettype none

module msb_first_bit_writer_core import mbw_pkg::*; (
	input  wire    clk,
	input  wire    arst_n,
	mbw_in_if.sink   item,
	mbw_out_if.source result
);

	// decode
	logic [VALUE_W-1:0]  val_u;
	logic [VALUE_W-1:0]  mask;
	logic [VALUE_W-1:0]  mag;
	logic                neg;
	logic [VALUE_W-1:0]  pos_n;
	logic [CNT_W-1:0]    pos_len;
	logic [CNT_W-1:0]    pos_lenlen;
	logic [FIELD_W-1:0]  raw_r;
	logic [CNT_W-1:0]    raw_len;
	logic                raw_flush;
	logic [FIELD_W-1:0]  fld_c;

	// input register
	logic                valid_s1;
	logic [FIELD_W-1:0]  fld_s1;
	logic [CNT_W-1:0]    len_s1;
	logic                flush_s1;

	// accumulator and output
	logic [ACC_W-1:0]    acc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                flush_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic [VBITS_W-1:0]  out_vbits_q;
	logic                out_last_q;

	logic                load;
	logic                emit_ok;
	logic                emit;
	logic [ACC_W-1:0]    cur_acc;
	logic [CNT_W-1:0]    cur_cnt;
	logic                cur_flush;

	always_comb begin
		val_u      = VALUE_W'(item.field_value);
		mask       = (VALUE_W'(1) << item.field_bits) - VALUE_W'(1);
		neg        = val_u[VALUE_W-1];
		mag        = neg ? (VALUE_W'(0) - val_u) : val_u;
		pos_n      = {1'b0, val_u[VALUE_W-2:0]};
		pos_len    = width_of(pos_n);
		pos_lenlen = width_of(VALUE_W'(pos_len - CNT_W'(1)));
		raw_r      = '0;
		raw_len    = '0;
		raw_flush  = 1'b0;
		case (action_t'(item.action))
			ACT_RAW: begin
				raw_r   = FIELD_W'(val_u & mask);
				raw_len = CNT_W'(item.field_bits);
			end
			ACT_SIGNED: begin
				raw_r   = (FIELD_W'(neg) << item.field_bits) | FIELD_W'(mag & mask);
				raw_len = CNT_W'(item.field_bits) + CNT_W'(1);
			end
			ACT_POS_CODE: begin
				raw_r   = (FIELD_W'(pos_lenlen - CNT_W'(1)) << (pos_lenlen + pos_len))
					| (FIELD_W'(pos_len - CNT_W'(1)) << pos_len)
					| FIELD_W'(pos_n);
				raw_len = CNT_W'(3) + pos_lenlen + pos_len;
			end
			ACT_FLUSH: begin
				raw_flush = 1'b1;
			end
			default: begin
				raw_flush = 1'b0;
			end
		endcase
		fld_c = raw_r << (CNT_W'(FIELD_W) - raw_len);
	end

	assign load       = valid_s1 && (cnt_q < CNT_W'(BYTE_W)) && !flush_q;
	assign item.ready = !valid_s1 || load;

	always_comb begin
		if (load) begin
			cur_acc   = acc_q | ({fld_s1, {(BYTE_W-1){1'b0}}} >> cnt_q[2:0]);
			cur_cnt   = cnt_q + len_s1;
			cur_flush = flush_s1 && (cnt_q != '0);
		end else begin
			cur_acc   = acc_q;
			cur_cnt   = cnt_q;
			cur_flush = flush_q;
		end
	end

	assign emit_ok = !out_valid_q || result.ready;
	assign emit    = emit_ok && ((cur_cnt >= CNT_W'(BYTE_W)) || cur_flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			fld_s1   <= fld_c;
			len_s1   <= raw_flush ? '0 : raw_len;
			flush_s1 <= raw_flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cnt_q   <= '0;
			flush_q <= 1'b0;
		end else if (emit) begin
			if (cur_flush) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= cur_acc << BYTE_W;
				cnt_q <= cur_cnt - CNT_W'(BYTE_W);
			end
			flush_q <= 1'b0;
		end else begin
			acc_q   <= cur_acc;
			cnt_q   <= cur_cnt;
			flush_q <= cur_flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= cur_acc[ACC_W-1 -: BYTE_W];
			out_vbits_q <= cur_flush ? cur_cnt[VBITS_W-1:0] : FULL_BYTE;
			out_last_q  <= cur_flush || (cur_cnt < CNT_W'(2 * BYTE_W));
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_byte   = out_byte_q;
	assign result.valid_bits = out_vbits_q;
	assign result.last       = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/mbw_checker.sv =====
// port-level checks of the msb-first bit writer and their bind
`default_nettype none

module mbw_checker import mbw_pkg::*; (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire [BYTE_W-1:0]    out_byte,
	input wire [VBITS_W-1:0]   valid_bits,
	input wire                 last
);

	// stalled byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(valid_bits) && $stable(last))
		else $error("stalled output byte changed");

	a_vbits_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> valid_bits != '0 && valid_bits <= FULL_BYTE)
		else $error("valid bit count out of range");

	// a partial byte only comes from a flush and ends its request
	a_partial_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_bits != FULL_BYTE |-> last)
		else $error("partial byte not marked last");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> BYTE_W'(out_byte << valid_bits) == '0)
		else $error("padding bits of partial byte not zero");

endmodule

bind msb_first_bit_writer_core mbw_checker u_mbw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_byte   (result.out_byte),
	.valid_bits (result.valid_bits),
	.last       (result.last)
);

`default_nettype wire
